>>> rtl/assert_macros.svh
// assertion macros shared by the correlator rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define DPXC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPXC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DPXC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DPXC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/dpxc_pkg.sv
// types, constants and saturating add for the dual-polarisation correlator
// no dependencies
package dpxc_pkg;

    localparam int MAX_STATIONS = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int ACC_BITS     = 48;

    localparam int IN_W      = 16;
    localparam int VIS_W     = 48;
    localparam int STATION_W = 6;
    localparam int CHANNEL_W = 12;
    localparam int MAX_CHANNELS = 4096;

    localparam int NUM_BL  = MAX_STATIONS * (MAX_STATIONS + 1) / 2;
    localparam int BL_W    = $clog2(NUM_BL);
    localparam int LINE_AW = $clog2(MAX_STATIONS);

    localparam int NUM_PAIR = 4;
    localparam int NUM_ACC  = 2 * NUM_PAIR;
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int TERM_W   = PROD_W + 1;
    localparam int SUM_W    = ((ACC_BITS > TERM_W) ? ACC_BITS : TERM_W) + 1;

    localparam int STCNT_W = 7;
    localparam int TCNT_W  = 16;
    localparam int CHCNT_W = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STATION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam int IN_TDATA_W  = 4 * IN_W;
    localparam int OUT_TDATA_W = 2 * STATION_W + CHANNEL_W + NUM_ACC * VIS_W;

    localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] y_im;
        logic signed [SAMPLE_BITS-1:0] y_re;
        logic signed [SAMPLE_BITS-1:0] x_im;
        logic signed [SAMPLE_BITS-1:0] x_re;
    } t_sample;

    typedef struct packed {
        logic [BL_W-1:0]      bl;
        logic [STATION_W-1:0] x;
        logic                 last;
    } t_tag;

    // order from index 0: xx_re xx_im xy_re xy_im yx_re yx_im yy_re yy_im
    typedef logic [NUM_ACC-1:0][ACC_BITS-1:0] t_acc_vec;
    typedef logic [NUM_ACC-1:0][VIS_W-1:0]    t_vis_vec;

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] acc,
        input logic signed [TERM_W-1:0]   term
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(term);
        if (s > SUM_W'(ACC_HI)) begin
            return ACC_HI;
        end else if (s < SUM_W'(ACC_LO)) begin
            return ACC_LO;
        end
        return ACC_BITS'(s);
    endfunction

endpackage

>>> rtl/dpxc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dpxc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/dpxc_mac.sv
// shared four-pair complex multiply-accumulate pipeline, one baseline per cycle
// depends on dpxc_pkg
module dpxc_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  dpxc_pkg::t_tag            i_tag,
    input  dpxc_pkg::t_sample         i_a,
    input  dpxc_pkg::t_sample         i_b,
    input  logic                      i_first,
    input  dpxc_pkg::t_acc_vec        i_acc,
    output logic [dpxc_pkg::BL_W-1:0] o_rd_addr,
    output logic                      o_valid,
    output dpxc_pkg::t_tag            o_tag,
    output dpxc_pkg::t_acc_vec        o_sum,
    output logic                      o_busy
);
    import dpxc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] a_re [NUM_PAIR];
    logic signed [SAMPLE_BITS-1:0] a_im [NUM_PAIR];
    logic signed [SAMPLE_BITS-1:0] b_re [NUM_PAIR];
    logic signed [SAMPLE_BITS-1:0] b_im [NUM_PAIR];

    logic signed [PROD_W-1:0] r_p_rr [NUM_PAIR];
    logic signed [PROD_W-1:0] r_p_ii [NUM_PAIR];
    logic signed [PROD_W-1:0] r_p_ir [NUM_PAIR];
    logic signed [PROD_W-1:0] r_p_ri [NUM_PAIR];

    logic signed [TERM_W-1:0] r_t_re [NUM_PAIR];
    logic signed [TERM_W-1:0] r_t_im [NUM_PAIR];

    logic signed [ACC_BITS-1:0] old_acc [NUM_ACC];

    logic     r_v2, r_v3, r_v4;
    t_tag     r_tag2, r_tag3, r_tag4;
    t_acc_vec r_sum;

    // pair order xx xy yx yy: first letter from station x, second from station y
    always_comb begin
        for (int k = 0; k < NUM_PAIR; k++) begin
            a_re[k] = (k >= 2) ? i_a.y_re : i_a.x_re;
            a_im[k] = (k >= 2) ? i_a.y_im : i_a.x_im;
            b_re[k] = (k == 1 || k == 3) ? i_b.y_re : i_b.x_re;
            b_im[k] = (k == 1 || k == 3) ? i_b.y_im : i_b.x_im;
        end
        for (int j = 0; j < NUM_ACC; j++) begin
            old_acc[j] = i_first ? '0 : signed'(i_acc[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag2 <= i_tag;
        r_tag3 <= r_tag2;
        r_tag4 <= r_tag3;
        for (int k = 0; k < NUM_PAIR; k++) begin
            r_p_rr[k] <= a_re[k] * b_re[k];
            r_p_ii[k] <= a_im[k] * b_im[k];
            r_p_ir[k] <= a_im[k] * b_re[k];
            r_p_ri[k] <= a_re[k] * b_im[k];
            r_t_re[k] <= TERM_W'(r_p_rr[k]) + TERM_W'(r_p_ii[k]);
            r_t_im[k] <= TERM_W'(r_p_ir[k]) - TERM_W'(r_p_ri[k]);
            r_sum[2*k]   <= sat_add(old_acc[2*k], r_t_re[k]);
            r_sum[2*k+1] <= sat_add(old_acc[2*k+1], r_t_im[k]);
        end
    end

    assign o_rd_addr = r_tag2.bl;
    assign o_valid   = r_v4;
    assign o_tag     = r_tag4;
    assign o_sum     = r_sum;
    assign o_busy    = r_v2 | r_v3 | r_v4;

endmodule

>>> rtl/dual_pol_cross_correlator_top.sv
// top level of the dual-polarisation cross-correlator: sequencer, line store,
// accumulator store and output register; depends on dpxc_pkg, dpxc_ram, dpxc_mac
// and assert_macros.svh
`include "assert_macros.svh"

// Samples arrive station by station, then time, then channel; each station y
// updates the baselines x = 0..y through one shared four-pair complex MAC,
// one baseline per cycle except on the last time step. An ordinary item issues
// its y+1 baselines and drains the pipeline before the next transfer is taken.
// On the last time step each baseline is issued only once the previous
// visibility has left the output register, so such an item also waits on any
// stall on the output side. Accumulators of the first time step start from
// zero without a clearing pass, so the block is ready straight after reset and
// after any write to a count register (which restarts the run).
module dual_pol_cross_correlator_top
    import dpxc_pkg::IN_TDATA_W, dpxc_pkg::OUT_TDATA_W, dpxc_pkg::CFG_IDX_W,
           dpxc_pkg::CFG_DATA_W;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pol_x_re, pol_x_im, pol_y_re, pol_y_im
    // visibility output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // first_station, second_station,
                                                  // channel_number, xx_re, xx_im,
                                                  // xy_re, xy_im, yx_re, yx_im,
                                                  // yy_re, yy_im
    output logic                   m_axis_tlast   // run_last
);
    import dpxc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;

    logic [STCNT_W-1:0] r_station_count;
    logic [TCNT_W-1:0]  r_time_count;
    logic [CHCNT_W-1:0] r_channel_count;
    logic [STCNT_W-1:0] n_st;
    logic [TCNT_W-1:0]  n_t;
    logic [CHCNT_W-1:0] n_ch;

    logic [STATION_W-1:0] r_st_cnt;
    logic [TCNT_W-1:0]    r_t_cnt;
    logic [CHANNEL_W-1:0] r_ch_cnt;
    logic [BL_W-1:0]      r_base;

    logic [STATION_W-1:0] r_y;
    logic [STATION_W-1:0] r_x;
    logic [BL_W-1:0]      r_item_base;
    logic [CHANNEL_W-1:0] r_item_ch;
    logic                 r_last_time;
    logic                 r_first;
    t_sample              r_cur;

    logic r_s1_valid;
    t_tag r_s1_tag;

    logic                 r_out_valid;
    logic [STATION_W-1:0] r_out_first;
    logic [STATION_W-1:0] r_out_second;
    logic [CHANNEL_W-1:0] r_out_ch;
    t_vis_vec             r_out_vis;
    logic                 r_out_last;

    logic     cfg_fire, in_fire, issue, busy, last_time_now, last_station;
    t_sample  in_sample;
    t_sample  line_rdata;
    t_acc_vec acc_rdata;
    logic [BL_W-1:0] acc_raddr;
    logic     mac_valid, mac_busy;
    t_tag     mac_tag;
    t_acc_vec mac_sum;

    assign o_cfg_ready   = 1'b1;
    assign cfg_fire      = i_cfg_valid & o_cfg_ready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign busy          = r_s1_valid | mac_busy;

    always_comb begin
        n_st = r_station_count;
        if (r_station_count == '0) begin
            n_st = STCNT_W'(1);
        end else if (r_station_count > STCNT_W'(MAX_STATIONS)) begin
            n_st = STCNT_W'(MAX_STATIONS);
        end
        n_t = (r_time_count == '0) ? TCNT_W'(1) : r_time_count;
        n_ch = r_channel_count;
        if (r_channel_count == '0) begin
            n_ch = CHCNT_W'(1);
        end else if (r_channel_count > CHCNT_W'(MAX_CHANNELS)) begin
            n_ch = CHCNT_W'(MAX_CHANNELS);
        end
    end

    assign last_time_now = ((TCNT_W+1)'(r_t_cnt) + (TCNT_W+1)'(1)) >= (TCNT_W+1)'(n_t);
    assign last_station  = (STCNT_W'(r_st_cnt) + STCNT_W'(1)) >= n_st;

    always_comb begin
        in_sample.x_re = s_axis_tdata[0*IN_W +: SAMPLE_BITS];
        in_sample.x_im = s_axis_tdata[1*IN_W +: SAMPLE_BITS];
        in_sample.y_re = s_axis_tdata[2*IN_W +: SAMPLE_BITS];
        in_sample.y_im = s_axis_tdata[3*IN_W +: SAMPLE_BITS];
    end

    // during the last time step wait for the previous visibility to leave
    assign issue = (r_state == ST_WALK) && (!r_last_time || (!busy && !r_out_valid));

    // config registers and run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_count <= STCNT_W'(MAX_STATIONS);
            r_time_count    <= TCNT_W'(256);
            r_channel_count <= CHCNT_W'(1);
            r_st_cnt        <= '0;
            r_t_cnt         <= '0;
            r_ch_cnt        <= '0;
            r_base          <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_STATION_COUNT: r_station_count <= i_cfg_data[STCNT_W-1:0];
                REG_TIME_COUNT:    r_time_count    <= i_cfg_data[TCNT_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHCNT_W-1:0];
                default: ;
            endcase
            if (i_cfg_index == REG_STATION_COUNT || i_cfg_index == REG_TIME_COUNT
                || i_cfg_index == REG_CHANNEL_COUNT) begin
                r_st_cnt <= '0;
                r_t_cnt  <= '0;
                r_ch_cnt <= '0;
                r_base   <= '0;
            end
        end else if (in_fire) begin
            if (last_station) begin
                r_st_cnt <= '0;
                r_base   <= '0;
                if (last_time_now) begin
                    r_t_cnt <= '0;
                    if ((CHCNT_W'(r_ch_cnt) + CHCNT_W'(1)) >= n_ch) begin
                        r_ch_cnt <= '0;
                    end else begin
                        r_ch_cnt <= r_ch_cnt + CHANNEL_W'(1);
                    end
                end else begin
                    r_t_cnt <= r_t_cnt + TCNT_W'(1);
                end
            end else begin
                r_st_cnt <= r_st_cnt + STATION_W'(1);
                r_base   <= r_base + BL_W'(r_st_cnt) + BL_W'(1);
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (issue && r_x == r_y) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cur       <= in_sample;
            r_y         <= r_st_cnt;
            r_item_base <= r_base;
            r_item_ch   <= r_ch_cnt;
            r_last_time <= last_time_now;
            r_first     <= (r_t_cnt == '0);
            r_x         <= '0;
        end else if (issue) begin
            r_x <= r_x + STATION_W'(1);
        end
        if (issue) begin
            r_s1_tag.bl   <= r_item_base + BL_W'(r_x);
            r_s1_tag.x    <= r_x;
            r_s1_tag.last <= (r_x == r_y);
        end
    end

    dpxc_ram #(
        .WIDTH ($bits(t_sample)),
        .DEPTH (MAX_STATIONS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (LINE_AW'(r_st_cnt)),
        .i_wdata (in_sample),
        .i_raddr (LINE_AW'(r_x)),
        .o_rdata (line_rdata)
    );

    dpxc_ram #(
        .WIDTH ($bits(t_acc_vec)),
        .DEPTH (NUM_BL)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (mac_valid & ~r_last_time),
        .i_waddr (mac_tag.bl),
        .i_wdata (mac_sum),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    dpxc_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_tag     (r_s1_tag),
        .i_a       (line_rdata),
        .i_b       (r_cur),
        .i_first   (r_first),
        .i_acc     (acc_rdata),
        .o_rd_addr (acc_raddr),
        .o_valid   (mac_valid),
        .o_tag     (mac_tag),
        .o_sum     (mac_sum),
        .o_busy    (mac_busy)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mac_valid && r_last_time) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_valid && r_last_time) begin
            r_out_first  <= mac_tag.x;
            r_out_second <= r_y;
            r_out_ch     <= r_item_ch;
            r_out_last   <= mac_tag.last;
            for (int j = 0; j < NUM_ACC; j++) begin
                r_out_vis[j] <= VIS_W'(signed'(mac_sum[j]));
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_vis, r_out_ch, r_out_second, r_out_first};

    `DPXC_ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, s_axis_tready, !busy, "ready while baselines in flight")
    `DPXC_ASSERT_IMP(a_out_no_overrun, i_clk, i_rst_n, mac_valid && r_last_time, !r_out_valid, "visibility overwrites pending output")
    `DPXC_ASSERT_IMP(a_last_is_diag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, r_out_first == r_out_second, "run_last on off-diagonal baseline")
    `DPXC_ASSERT_NXT(a_accept_walks, i_clk, i_rst_n, in_fire, r_state == ST_WALK, "accepted sample not walked")

endmodule

>>> dv/tb.sv
// self-checking testbench for dual_pol_cross_correlator_top: streams dual-pol samples,
// predicts every visibility with an in-bench correlator and checks each output transfer
// depends on dpxc_pkg and the correlator rtl
module tb;
    import dpxc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 2 * MAX_STATIONS + 16;
    localparam int RANDOM_ITEMS  = 200;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint VIS_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint VIS_MIN = -VIS_MAX - 1;

    typedef struct packed {
        logic [STATION_W-1:0] first_st;
        logic [STATION_W-1:0] second_st;
        logic [CHANNEL_W-1:0] chan;
        t_vis_vec             vis;
        logic                 last;
    } vis_rec_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // correlator state mirrored in the bench
    logic [STCNT_W-1:0] cfg_stations;
    logic [TCNT_W-1:0]  cfg_times;
    logic [CHCNT_W-1:0] cfg_channels;
    t_sample            line_store [MAX_STATIONS];
    longint             acc_store [NUM_ACC][NUM_BL];
    int unsigned        station_ctr;
    int unsigned        time_ctr;
    int unsigned        channel_ctr;
    vis_rec_t           pending_vis [$];

    int unsigned samples_sent;
    int unsigned vis_seen;
    int unsigned settings_written;
    int unsigned error_count;
    int unsigned sample_gap;
    int unsigned out_stall;
    bit          sample_held;
    bit          in_no_idle;
    bit          out_no_idle;
    string       vis_names [NUM_ACC] = '{"xx_re", "xx_im", "xy_re", "xy_im",
                                         "yx_re", "yx_im", "yy_re", "yy_im"};

    dual_pol_cross_correlator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = !i_clk;

    function automatic int unsigned draw_wait(inout bit no_idle);
        if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > VIS_MAX) return VIS_MAX;
        if (v < VIS_MIN) return VIS_MIN;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            2: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_sample make_sample(input logic signed [SAMPLE_BITS-1:0] xr, xi,
                                            yr, yi);
        t_sample s;
        s.x_re = xr;
        s.x_im = xi;
        s.y_re = yr;
        s.y_im = yi;
        return s;
    endfunction

    function automatic t_sample rand_sample();
        return make_sample(rand_part(), rand_part(), rand_part(), rand_part());
    endfunction

    task automatic restart_correlator();
        int k;
        int b;
        for (k = 0; k < NUM_ACC; k++) begin
            for (b = 0; b < NUM_BL; b++) begin
                acc_store[k][b] = 0;
            end
        end
        station_ctr = 0;
        time_ctr    = 0;
        channel_ctr = 0;
    endtask

    // accumulate one station against the line and queue the visibilities it releases
    task automatic correlate_sample(input t_sample s);
        int unsigned n_st;
        int unsigned n_t;
        int unsigned n_ch;
        int unsigned y;
        int unsigned base;
        int unsigned bl;
        int          x;
        int          p;
        int          k;
        bit          last_t;
        longint      ar;
        longint      ai;
        longint      br;
        longint      bi;
        t_sample     a;
        vis_rec_t    r;
        n_st = (cfg_stations == 0) ? 1 :
               ((cfg_stations > MAX_STATIONS) ? MAX_STATIONS : cfg_stations);
        n_t  = (cfg_times == 0) ? 1 : cfg_times;
        n_ch = (cfg_channels == 0) ? 1 :
               ((cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels);
        y = station_ctr;
        line_store[y] = s;
        base = y * (y + 1) / 2;
        for (x = 0; x <= y; x++) begin
            a  = line_store[x];
            bl = base + x;
            for (p = 0; p < NUM_PAIR; p++) begin
                ar = (p >= 2) ? a.y_re : a.x_re;
                ai = (p >= 2) ? a.y_im : a.x_im;
                br = (p % 2 == 1) ? s.y_re : s.x_re;
                bi = (p % 2 == 1) ? s.y_im : s.x_im;
                acc_store[2*p][bl]   = clamp_acc(acc_store[2*p][bl] + ar * br + ai * bi);
                acc_store[2*p+1][bl] = clamp_acc(acc_store[2*p+1][bl] + ai * br - ar * bi);
            end
        end
        last_t = (time_ctr + 1 >= n_t);
        if (last_t) begin
            for (x = 0; x <= y; x++) begin
                bl = base + x;
                r.first_st  = STATION_W'(x);
                r.second_st = STATION_W'(y);
                r.chan      = CHANNEL_W'(channel_ctr);
                for (k = 0; k < NUM_ACC; k++) begin
                    r.vis[k] = VIS_W'(acc_store[k][bl]);
                    acc_store[k][bl] = 0;
                end
                r.last = (x == y);
                pending_vis.push_back(r);
            end
        end
        if (y + 1 >= n_st) begin
            station_ctr = 0;
            if (last_t) begin
                time_ctr    = 0;
                channel_ctr = (channel_ctr + 1 >= n_ch) ? 0 : channel_ctr + 1;
            end else begin
                time_ctr++;
            end
        end else begin
            station_ctr = y + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit keep_valid);
        bit known;
        known = 1'b1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!keep_valid) i_cfg_valid <= 1'b0;
        settings_written++;
        case (idx)
            REG_STATION_COUNT: cfg_stations = val[STCNT_W-1:0];
            REG_TIME_COUNT:    cfg_times    = val[TCNT_W-1:0];
            REG_CHANNEL_COUNT: cfg_channels = val[CHCNT_W-1:0];
            default:           known = 1'b0;
        endcase
        if (known) restart_correlator();
    endtask

    task automatic configure(input int unsigned st, tm, ch);
        write_reg(REG_STATION_COUNT, CFG_DATA_W'(st), 1'b1);
        write_reg(REG_TIME_COUNT, CFG_DATA_W'(tm), 1'b1);
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch), 1'b0);
    endtask

    task automatic send_sample(input t_sample s);
        if (sample_gap > 0) repeat (sample_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        correlate_sample(s);
        sample_gap  = draw_wait(in_no_idle);
        sample_held = (sample_gap == 0);
        if (!sample_held) s_axis_tvalid <= 1'b0;
    endtask

    task automatic park_samples();
        if (sample_held) begin
            s_axis_tvalid <= 1'b0;
            sample_held = 1'b0;
            if (sample_gap == 0) sample_gap = 1;
        end
    endtask

    task automatic drain_results();
        park_samples();
        while (pending_vis.size() != 0) @(posedge i_clk);
    endtask

    // items that release nothing may still be in the pipe once the queue is empty
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) send_sample(rand_sample());
    endtask

    task automatic test_reset_defaults();
        send_random(3);
        settle();
    endtask

    task automatic test_bad_index();
        configure(2, 2, 2);
        send_random(2);
        settle();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom), 1'b0);
        send_random(2);
        settle();
    endtask

    task automatic test_extreme_samples();
        configure(1, 1, 1);
        send_sample(make_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_sample(make_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_sample(make_sample(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000));
        send_sample(make_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_sample(make_sample(-16'sd1, 16'sd1, 16'sd1, -16'sd1));
        settle();
    endtask

    task automatic test_channel_wrap();
        configure(1, 1, 3);
        send_random(4);
        settle();
    endtask

    task automatic test_zero_counts();
        configure(0, 0, 0);
        send_random(2);
        settle();
    endtask

    // station count above the array size, channel count whose 13 bits are all zero
    task automatic test_oversize_counts();
        configure(100, 1, 8192);
        send_random(3);
        settle();
    endtask

    task automatic test_long_integration();
        configure(2, 65535, 4096);
        send_random(3);
        settle();
    endtask

    // whole array with one wrap of the station counter, and a full pause half way
    task automatic test_full_array();
        int i;
        configure(127, 1, 5000);
        for (i = 0; i < MAX_STATIONS + 2; i++) begin
            if (i == MAX_STATIONS / 2) drain_results();
            send_sample(rand_sample());
        end
        settle();
    endtask

    task automatic test_random_runs();
        int unsigned start;
        int unsigned st;
        int unsigned tm;
        int unsigned ch;
        int unsigned n;
        int unsigned i;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS - MAX_STATIONS - 2) begin
            st = $urandom_range(0, 10);
            tm = $urandom_range(0, 4);
            ch = $urandom_range(0, 4);
            configure(st, tm, ch);
            n = (st == 0 ? 1 : st) * (tm == 0 ? 1 : tm) * $urandom_range(1, 3)
                + $urandom_range(0, 2);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 31) == 0) drain_results();
                send_sample(rand_sample());
            end
            settle();
        end
    endtask

    always @(posedge i_clk) begin : vis_check
        vis_rec_t got;
        vis_rec_t want;
        int k;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_stall = draw_wait(out_no_idle);
        end else if (m_axis_tvalid && m_axis_tready) begin
            got.first_st  = m_axis_tdata[0 +: STATION_W];
            got.second_st = m_axis_tdata[STATION_W +: STATION_W];
            got.chan      = m_axis_tdata[2*STATION_W +: CHANNEL_W];
            got.vis       = m_axis_tdata[2*STATION_W+CHANNEL_W +: NUM_ACC*VIS_W];
            got.last      = m_axis_tlast;
            vis_seen++;
            if (pending_vis.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected visibility %0d-%0d ch %0d", got.first_st,
                             got.second_st, got.chan);
            end else begin
                want = pending_vis.pop_front();
                compare_field("first_station", want, want.first_st, got.first_st);
                compare_field("second_station", want, want.second_st, got.second_st);
                compare_field("channel_number", want, want.chan, got.chan);
                for (k = 0; k < NUM_ACC; k++) begin
                    compare_field(vis_names[k], want, want.vis[k], got.vis[k]);
                end
                compare_field("run_last", want, want.last, got.last);
            end
            out_stall = draw_wait(out_no_idle);
            if (out_stall != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (out_stall == 0) m_axis_tready <= 1'b1;
            else out_stall--;
        end
    end

    task automatic compare_field(input string name, input vis_rec_t want,
                                 input logic [VIS_W-1:0] w, input logic [VIS_W-1:0] g);
        if (w !== g) begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch %s on baseline %0d-%0d ch %0d: expected %0h, got %0h",
                         name, want.first_st, want.second_st, want.chan, w, g);
        end
    endtask

    initial begin
        cfg_stations = STCNT_W'(MAX_STATIONS);
        cfg_times    = TCNT_W'(256);
        cfg_channels = CHCNT_W'(1);
        restart_correlator();
        sample_gap = draw_wait(in_no_idle);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_bad_index();
        test_extreme_samples();
        test_channel_wrap();
        test_zero_counts();
        test_oversize_counts();
        test_long_integration();
        test_full_array();
        test_random_runs();

        settle();
        $display("covered %0d samples and %0d visibilities over %0d register writes",
                 samples_sent, vis_seen, settings_written);
        $display("including full-scale samples, every count at its limits and a bad index");
        if (error_count == 0 && pending_vis.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d visibilities outstanding", pending_vis.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
